@@ design/kst_pkg.sv @@
// kst_pkg: shared types and constants for the spanning tree engine
// no dependencies
`timescale 1ns / 1ps
package kst_pkg;
    localparam int RANK_MAX    = 7;
    // a run never reports more tree edges than this
    localparam int MAX_RESULTS = 63;
    typedef logic [2:0] rank_t;
endpackage

@@ design/kst_if.sv @@
// kst_if: valid/ready channel carrying one edge word
// depends on nothing
`timescale 1ns / 1ps
interface kst_edge_if;
    logic        valid;
    logic        ready;
    logic [5:0]  first_vertex;
    logic [5:0]  second_vertex;
    logic [31:0] edge_weight;
    logic        final_edge;
    modport source (output valid, first_vertex, second_vertex, edge_weight, final_edge,
                    input ready);
    modport sink (input valid, first_vertex, second_vertex, edge_weight, final_edge,
                  output ready);
endinterface

interface kst_tree_if;
    logic        valid;
    logic        ready;
    logic [5:0]  tree_first;
    logic [5:0]  tree_second;
    logic [31:0] tree_weight;
    logic        run_end;
    logic        no_tree_edge;
    logic        capacity_exceeded;
    modport source (output valid, tree_first, tree_second, tree_weight, run_end,
                    no_tree_edge, capacity_exceeded, input ready);
    modport sink (input valid, tree_first, tree_second, tree_weight, run_end,
                  no_tree_edge, capacity_exceeded, output ready);
endinterface

@@ design/kst_ram.sv @@
// kst_ram: generic single-port-write, one-read synchronous ram
// no dependencies
`timescale 1ns / 1ps
module kst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ design/kruskal_spanning_tree.sv @@
// kruskal_spanning_tree: top level of the minimum spanning tree engine
// depends on kst_pkg, kst_if, kst_ram
//
// usage
//   edge_in takes one edge word per cycle while loading (ready high).
//   a word with final_edge set ends the set and starts the run; edge_in
//   drops ready until the last tree word of the run has been taken.
//   edges beyond MAX_EDGES are dropped and flagged in capacity_exceeded,
//   which carries the same value on every word of the run.
// run
//   the store is sorted in place by insertion sort, then a table sweep
//   resets every one of the MAX_VERTICES entries; then each edge gets a find
//   walk and a compression walk on each end, a link by rank when the roots
//   differ and a rank bump when both ranks are equal and below RANK_MAX; an
//   edge with an id out of range is skipped.
//   every accepted edge becomes one tree word, held back one step so that
//   the last one can carry run_end; a run with no accepted edge gives one
//   word with no_tree_edge set.
// stall
//   tree_out holds its word until ready; the engine waits in its emit or final step.
// reset
//   rst_n clears all control state; the parent table is swept in each run before
//   the edges are examined, so no clearing pass follows reset.
`timescale 1ns / 1ps
module kruskal_spanning_tree
    import kst_pkg::*;
#(
    parameter int MAX_EDGES    = 64,
    parameter int MAX_VERTICES = 64,
    parameter int WEIGHT_BITS  = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    kst_edge_if.sink   edge_in,
    kst_tree_if.source tree_out
);
    localparam int EA = $clog2(MAX_EDGES);
    localparam int VA = $clog2(MAX_VERTICES);
    localparam int CW = EA + 1;
    localparam int EW = 44;
    // weights keep only their low WEIGHT_BITS bits
    localparam logic [31:0] WMASK = (WEIGHT_BITS >= 32) ? 32'hFFFF_FFFF :
                                    32'((64'd1 << WEIGHT_BITS) - 64'd1);

    localparam logic [3:0] S_LOAD  = 4'd0;
    localparam logic [3:0] S_SRDK  = 4'd1;   // read key at i
    localparam logic [3:0] S_SKEY  = 4'd2;   // latch key, read j-1
    localparam logic [3:0] S_SCMP  = 4'd3;   // compare, shift or place
    localparam logic [3:0] S_CLR   = 4'd4;   // table sweep
    localparam logic [3:0] S_ERD   = 4'd5;   // read edge
    localparam logic [3:0] S_ELAT  = 4'd6;   // latch edge, range check
    localparam logic [3:0] S_FRD   = 4'd7;   // read start of find walk
    localparam logic [3:0] S_FCHK  = 4'd8;   // walk to root
    localparam logic [3:0] S_CRD   = 4'd9;   // read start of compression walk
    localparam logic [3:0] S_CCHK  = 4'd10;  // compression walk
    localparam logic [3:0] S_LINK  = 4'd11;  // union by rank
    localparam logic [3:0] S_BUMP  = 4'd12;  // rank increment
    localparam logic [3:0] S_EMIT  = 4'd13;  // pass held word on
    localparam logic [3:0] S_FIN   = 4'd14;  // last word of the run
    localparam logic [3:0] S_DRAIN = 4'd15;  // wait for last word taken

    logic [3:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] j_reg, j_next;
    logic          ovf_reg, ovf_next;
    logic [EW-1:0] key_reg, key_next;
    logic [EW-1:0] edge_reg, edge_next;
    logic [VA:0]   clr_reg, clr_next;
    logic [VA-1:0] x_reg, x_next;
    logic [VA-1:0] start_reg, start_next;
    logic [VA-1:0] root_reg, root_next;
    logic [VA-1:0] ru_reg, ru_next;
    rank_t         rku_reg, rku_next;
    rank_t         rkv_reg, rkv_next;
    logic          side_reg, side_next;
    logic [EW-1:0] held_reg, held_next;
    logic          held_v_reg, held_v_next;
    logic [5:0]    emit_reg, emit_next;
    logic          out_v_reg, out_v_next;
    logic [EW-1:0] out_edge_reg, out_edge_next;
    logic          out_end_reg, out_end_next;
    logic          out_none_reg, out_none_next;
    logic          out_cap_reg, out_cap_next;

    // edge store: {first, second, weight}
    logic          e_we;
    logic [EA-1:0] e_wa, e_ra;
    logic [EW-1:0] e_wd, e_rd;
    kst_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_edges (
        .clk(clk), .we(e_we), .waddr(e_wa), .wdata(e_wd), .raddr(e_ra), .rdata(e_rd));

    // parent and rank share one word per vertex
    logic          p_we;
    logic [VA-1:0] p_wa, p_ra;
    logic [VA+2:0] p_wd, p_rd;
    kst_ram #(.WIDTH(VA + 3), .DEPTH(MAX_VERTICES)) u_parent (
        .clk(clk), .we(p_we), .waddr(p_wa), .wdata(p_wd), .raddr(p_ra), .rdata(p_rd));

    wire [VA-1:0] p_par  = p_rd[VA+2:3];
    wire rank_t   p_rank = p_rd[2:0];

    wire in_acc   = edge_in.valid && edge_in.ready;
    wire out_acc  = tree_out.valid && tree_out.ready;
    wire out_free = !out_v_reg || out_acc;
    assign edge_in.ready = (state_reg == S_LOAD);

    assign tree_out.valid             = out_v_reg;
    assign tree_out.tree_first        = out_edge_reg[EW-1:EW-6];
    assign tree_out.tree_second       = out_edge_reg[EW-7:32];
    assign tree_out.tree_weight       = out_edge_reg[31:0];
    assign tree_out.run_end           = out_end_reg;
    assign tree_out.no_tree_edge      = out_none_reg;
    assign tree_out.capacity_exceeded = out_cap_reg;

    wire [31:0] kw = key_reg[31:0];
    wire [31:0] rw = e_rd[31:0];
    wire [5:0]  rd_a = e_rd[EW-1:EW-6];
    wire [5:0]  rd_b = e_rd[EW-7:32];
    // an edge touching an id beyond the table is never accepted
    wire rd_in_range = ({26'd0, rd_a} < 32'(MAX_VERTICES)) &&
                       ({26'd0, rd_b} < 32'(MAX_VERTICES));
    wire [VA-1:0] vb = VA'(edge_reg[EW-7:32]);

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        ovf_next      = ovf_reg;
        key_next      = key_reg;
        edge_next     = edge_reg;
        clr_next      = clr_reg;
        x_next        = x_reg;
        start_next    = start_reg;
        root_next     = root_reg;
        ru_next       = ru_reg;
        rku_next      = rku_reg;
        rkv_next      = rkv_reg;
        side_next     = side_reg;
        held_next     = held_reg;
        held_v_next   = held_v_reg;
        emit_next     = emit_reg;
        out_v_next    = out_v_reg && !out_acc;
        out_edge_next = out_edge_reg;
        out_end_next  = out_end_reg;
        out_none_next = out_none_reg;
        out_cap_next  = out_cap_reg;

        e_we = 1'b0;
        e_wa = count_reg[EA-1:0];
        e_wd = {edge_in.first_vertex, edge_in.second_vertex, edge_in.edge_weight & WMASK};
        e_ra = i_reg[EA-1:0];
        p_we = 1'b0;
        p_wa = x_reg;
        p_wd = {x_reg, rank_t'(0)};
        p_ra = x_reg;

        case (state_reg)
            S_LOAD:
            begin
                if (in_acc)
                begin
                    if (count_reg < CW'(MAX_EDGES))
                    begin
                        e_we       = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    // a dropped closing edge still starts the run
                    if (edge_in.final_edge)
                    begin
                        i_next     = CW'(1);
                        state_next = S_SRDK;
                    end
                end
            end
            S_SRDK:
            begin
                if (i_reg >= count_reg)
                begin
                    clr_next   = '0;
                    state_next = S_CLR;
                end
                else
                begin
                    e_ra       = i_reg[EA-1:0];
                    state_next = S_SKEY;
                end
            end
            S_SKEY:
            begin
                key_next   = e_rd;
                j_next     = i_reg;
                e_ra       = EA'(i_reg - CW'(1));
                state_next = S_SCMP;
            end
            S_SCMP:
            begin
                // strict compare keeps equal weights in arrival order
                if (j_reg != '0 && rw > kw)
                begin
                    e_we   = 1'b1;
                    e_wa   = j_reg[EA-1:0];
                    e_wd   = e_rd;
                    e_ra   = EA'(j_reg - CW'(2));
                    j_next = j_reg - CW'(1);
                end
                else
                begin
                    e_we       = 1'b1;
                    e_wa       = j_reg[EA-1:0];
                    e_wd       = key_reg;
                    i_next     = i_reg + CW'(1);
                    state_next = S_SRDK;
                end
            end
            S_CLR:
            begin
                p_we     = 1'b1;
                p_wa     = clr_reg[VA-1:0];
                p_wd     = {clr_reg[VA-1:0], rank_t'(0)};
                clr_next = clr_reg + (VA+1)'(1);
                if (clr_reg == (VA+1)'(MAX_VERTICES - 1))
                begin
                    i_next      = '0;
                    emit_next   = '0;
                    held_v_next = 1'b0;
                    state_next  = S_ERD;
                end
            end
            S_ERD:
            begin
                if (i_reg >= count_reg || emit_reg == 6'(MAX_RESULTS))
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    e_ra       = i_reg[EA-1:0];
                    state_next = S_ELAT;
                end
            end
            S_ELAT:
            begin
                edge_next = e_rd;
                if (rd_in_range)
                begin
                    x_next     = VA'(rd_a);
                    start_next = VA'(rd_a);
                    side_next  = 1'b0;
                    state_next = S_FRD;
                end
                else
                begin
                    i_next     = i_reg + CW'(1);
                    state_next = S_ERD;
                end
            end
            S_FRD:
            begin
                p_ra       = x_reg;
                state_next = S_FCHK;
            end
            S_FCHK:
            begin
                if (p_par == x_reg)
                begin
                    root_next = x_reg;
                    if (side_reg)
                    begin
                        rkv_next = p_rank;
                    end
                    else
                    begin
                        rku_next = p_rank;
                    end
                    x_next     = start_reg;
                    state_next = S_CRD;
                end
                else
                begin
                    x_next = p_par;
                    p_ra   = p_par;
                end
            end
            S_CRD:
            begin
                p_ra       = x_reg;
                state_next = S_CCHK;
            end
            S_CCHK:
            begin
                if (p_par == root_reg)
                begin
                    if (!side_reg)
                    begin
                        ru_next    = root_reg;
                        side_next  = 1'b1;
                        x_next     = vb;
                        start_next = vb;
                        state_next = S_FRD;
                    end
                    else
                    begin
                        state_next = S_LINK;
                    end
                end
                else
                begin
                    // point this node straight at the root, keep its rank
                    p_we   = 1'b1;
                    p_wa   = x_reg;
                    p_wd   = {root_reg, p_rank};
                    x_next = p_par;
                    p_ra   = p_par;
                end
            end
            S_LINK:
            begin
                // root_reg holds the root of the second end here
                if (ru_reg == root_reg)
                begin
                    i_next     = i_reg + CW'(1);
                    state_next = S_ERD;
                end
                else if (rku_reg < rkv_reg)
                begin
                    p_we       = 1'b1;
                    p_wa       = ru_reg;
                    p_wd       = {root_reg, rku_reg};
                    state_next = S_EMIT;
                end
                else
                begin
                    p_we = 1'b1;
                    p_wa = root_reg;
                    p_wd = {ru_reg, rkv_reg};
                    if (rku_reg == rkv_reg && rku_reg < rank_t'(RANK_MAX))
                    begin
                        state_next = S_BUMP;
                    end
                    else
                    begin
                        state_next = S_EMIT;
                    end
                end
            end
            S_BUMP:
            begin
                p_we       = 1'b1;
                p_wa       = ru_reg;
                p_wd       = {ru_reg, rank_t'(rku_reg + 1'b1)};
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!held_v_reg)
                begin
                    held_next   = edge_reg;
                    held_v_next = 1'b1;
                    emit_next   = emit_reg + 6'd1;
                    i_next      = i_reg + CW'(1);
                    state_next  = S_ERD;
                end
                else if (out_free)
                begin
                    out_v_next    = 1'b1;
                    out_edge_next = held_reg;
                    out_end_next  = 1'b0;
                    out_none_next = 1'b0;
                    out_cap_next  = ovf_reg;
                    held_next     = edge_reg;
                    emit_next     = emit_reg + 6'd1;
                    i_next        = i_reg + CW'(1);
                    state_next    = S_ERD;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    out_v_next    = 1'b1;
                    out_edge_next = held_v_reg ? held_reg : '0;
                    out_end_next  = 1'b1;
                    out_none_next = !held_v_reg;
                    out_cap_next  = ovf_reg;
                    count_next    = '0;
                    ovf_next      = 1'b0;
                    held_v_next   = 1'b0;
                    state_next    = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (out_acc)
                begin
                    state_next = S_LOAD;
                end
            end
            default: state_next = S_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_LOAD;
            count_reg    <= '0;
            i_reg        <= '0;
            j_reg        <= '0;
            ovf_reg      <= 1'b0;
            key_reg      <= '0;
            edge_reg     <= '0;
            clr_reg      <= '0;
            x_reg        <= '0;
            start_reg    <= '0;
            root_reg     <= '0;
            ru_reg       <= '0;
            rku_reg      <= '0;
            rkv_reg      <= '0;
            side_reg     <= 1'b0;
            held_reg     <= '0;
            held_v_reg   <= 1'b0;
            emit_reg     <= '0;
            out_v_reg    <= 1'b0;
            out_edge_reg <= '0;
            out_end_reg  <= 1'b0;
            out_none_reg <= 1'b0;
            out_cap_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            i_reg        <= i_next;
            j_reg        <= j_next;
            ovf_reg      <= ovf_next;
            key_reg      <= key_next;
            edge_reg     <= edge_next;
            clr_reg      <= clr_next;
            x_reg        <= x_next;
            start_reg    <= start_next;
            root_reg     <= root_next;
            ru_reg       <= ru_next;
            rku_reg      <= rku_next;
            rkv_reg      <= rkv_next;
            side_reg     <= side_next;
            held_reg     <= held_next;
            held_v_reg   <= held_v_next;
            emit_reg     <= emit_next;
            out_v_reg    <= out_v_next;
            out_edge_reg <= out_edge_next;
            out_end_reg  <= out_end_next;
            out_none_reg <= out_none_next;
            out_cap_reg  <= out_cap_next;
        end
    end
endmodule
